@@ rtl/lpmd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpmd_pkg;

    localparam int LEN_BITS = 24;
    localparam int PROD_BITS = LEN_BITS + 4;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BRACE = 8'h7B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_BEFORE,
        PH_CONTENT
    } phase_t;

    typedef struct packed {
        logic       has_res;
        logic [7:0] out_byte;
        logic       last;
        logic       empty_res;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/lpmd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpmd_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              chunk_end,
    output lpmd_pkg::result_t      res
);

    lpmd_pkg::phase_t                phase_reg, phase_next;
    logic [lpmd_pkg::LEN_BITS-1:0]   length_accum_reg, length_accum_next;
    logic [lpmd_pkg::LEN_BITS-1:0]   bytes_left_reg, bytes_left_next;
    logic                            digits_seen_reg, digits_seen_next;
    logic                            digits_closed_reg, digits_closed_next;
    logic                            drop_reg, drop_next;

    logic                            is_digit;
    logic [lpmd_pkg::PROD_BITS-1:0]  acc_wide;
    logic [lpmd_pkg::PROD_BITS-1:0]  acc_sum;
    logic [lpmd_pkg::LEN_BITS-1:0]   acc_sat;
    logic [lpmd_pkg::LEN_BITS-1:0]   left_dec;

    assign is_digit = (in_byte >= lpmd_pkg::CH_ZERO) && (in_byte <= lpmd_pkg::CH_NINE);
    assign acc_wide = {4'b0000, length_accum_reg};
    assign acc_sum  = (acc_wide << 3) + (acc_wide << 1)
                    + {{(lpmd_pkg::PROD_BITS-4){1'b0}}, in_byte[3:0]};
    assign acc_sat  = (acc_sum > {4'b0000, lpmd_pkg::LEN_MAX}) ? lpmd_pkg::LEN_MAX
                    : acc_sum[lpmd_pkg::LEN_BITS-1:0];
    assign left_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= lpmd_pkg::PH_HUNT;
            length_accum_reg  <= '0;
            bytes_left_reg    <= '0;
            digits_seen_reg   <= 1'b0;
            digits_closed_reg <= 1'b0;
            drop_reg          <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            length_accum_reg  <= length_accum_next;
            bytes_left_reg    <= bytes_left_next;
            digits_seen_reg   <= digits_seen_next;
            digits_closed_reg <= digits_closed_next;
            drop_reg          <= drop_next;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        length_accum_next  = length_accum_reg;
        bytes_left_next    = bytes_left_reg;
        digits_seen_next   = digits_seen_reg;
        digits_closed_next = digits_closed_reg;
        drop_next          = drop_reg;
        res                = '0;

        if (drop_reg) begin
            if (chunk_end) begin
                drop_next = 1'b0;
            end
        end else begin
            unique case (phase_reg)
                lpmd_pkg::PH_HUNT: begin
                    if (in_byte == lpmd_pkg::CH_COLON) begin
                        phase_next         = lpmd_pkg::PH_LENGTH;
                        length_accum_next  = '0;
                        digits_seen_next   = 1'b0;
                        digits_closed_next = 1'b0;
                    end
                end
                lpmd_pkg::PH_LENGTH: begin
                    if (in_byte == lpmd_pkg::CH_CR) begin
                        phase_next      = lpmd_pkg::PH_BEFORE;
                        bytes_left_next = length_accum_reg;
                    end else if (!digits_closed_reg) begin
                        if (is_digit) begin
                            length_accum_next = acc_sat;
                            digits_seen_next  = 1'b1;
                        end else if (!(in_byte == lpmd_pkg::CH_SPACE && !digits_seen_reg)) begin
                            digits_closed_next = 1'b1;
                        end
                    end
                end
                lpmd_pkg::PH_BEFORE,
                lpmd_pkg::PH_CONTENT: begin
                    if (phase_reg == lpmd_pkg::PH_CONTENT || in_byte == lpmd_pkg::CH_BRACE) begin
                        res.has_res = 1'b1;
                        if (bytes_left_reg == '0 && phase_reg == lpmd_pkg::PH_BEFORE) begin
                            res.empty_res = 1'b1;
                            res.last      = 1'b1;
                        end else begin
                            res.out_byte    = in_byte;
                            res.last        = (left_dec == '0);
                            bytes_left_next = left_dec;
                            phase_next      = lpmd_pkg::PH_CONTENT;
                        end
                        if (res.last) begin
                            // close the message, drop the rest of the chunk
                            phase_next         = lpmd_pkg::PH_HUNT;
                            length_accum_next  = '0;
                            digits_seen_next   = 1'b0;
                            digits_closed_next = 1'b0;
                            bytes_left_next    = '0;
                            drop_next          = !chunk_end;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/length_prefixed_message_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Length-prefixed message deframer.
// Input stream: one received byte per request on s_tdata, s_tlast marks the
// last byte of a received chunk. The block finds a colon, reads a decimal
// length (leading spaces skipped, saturating at the 24-bit maximum), waits for
// a carriage return and then an opening brace, and from the brace on passes
// exactly that many bytes to the output stream.
// Output stream: m_tdata carries a content byte, m_tlast marks the final byte
// of a message, m_tuser marks a zero-length message (one empty request with
// m_tlast set and m_tdata zero). After a message the rest of its chunk is
// dropped.
// A result is registered and appears on the output in the cycle after its
// byte is taken. Throughput: one byte per cycle unless the receiver stalls;
// parsing is one combinational step between the parser state and output regs.
// Reset (aresetn low, synchronous) returns the parser to colon hunting and
// empties the output register.
// When the receiver stalls, the held result stays on m_ and s_tready drops
// until it is taken; s_tready is high whenever the output register is free
// or is being emptied in the same cycle.
module length_prefixed_message_deframer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // chunk_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // last
    output logic            m_tuser    // [0] empty_res
);

    lpmd_pkg::result_t res;
    logic              accept;
    logic              m_valid_reg;
    logic [7:0]        m_data_reg;
    logic              m_last_reg;
    logic              m_user_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    lpmd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_byte   (s_tdata),
        .chunk_end (s_tlast),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= accept && res.has_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            m_data_reg <= res.out_byte;
            m_last_reg <= res.last;
            m_user_reg <= res.empty_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00))
        else $error("empty marker without last or with data");

    a_stalled_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled result lost");

endmodule

`default_nettype wire

@@ tb/deframe_monitor.sv @@
`timescale 1ns / 1ps

module deframe_monitor (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic       m_tlast,
    input  wire logic       m_tuser,
    output int              fails,
    output int              pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } frame_byte_t;

    frame_byte_t                   frame_bytes[$];

    lpmd_pkg::phase_t              ph;
    logic [lpmd_pkg::LEN_BITS-1:0] len_acc;
    logic                          seen_digit;
    logic                          num_closed;
    logic [lpmd_pkg::LEN_BITS-1:0] left;
    logic                          dropping;

    task automatic clear_parser(input logic drop);
        ph         = lpmd_pkg::PH_HUNT;
        len_acc    = '0;
        seen_digit = 1'b0;
        num_closed = 1'b0;
        left       = '0;
        dropping   = drop;
    endtask

    task automatic add_expected(input logic [7:0] d, input logic l, input logic e);
        frame_byte_t item;
        item        = '{d, l, e};
        frame_bytes = {frame_bytes, item};
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic chunk_end);
        longint unsigned v;
        if (dropping) begin
            if (chunk_end) begin
                dropping = 1'b0;
            end
        end else begin
            case (ph)
                lpmd_pkg::PH_HUNT: begin
                    if (b == lpmd_pkg::CH_COLON) begin
                        clear_parser(1'b0);
                        ph = lpmd_pkg::PH_LENGTH;
                    end
                end
                lpmd_pkg::PH_LENGTH: begin
                    if (b == lpmd_pkg::CH_CR) begin
                        ph   = lpmd_pkg::PH_BEFORE;
                        left = len_acc;
                    end else if (!num_closed) begin
                        if (b >= lpmd_pkg::CH_ZERO && b <= lpmd_pkg::CH_NINE) begin
                            v = longint'(len_acc) * 10
                              + (longint'(b) - longint'(lpmd_pkg::CH_ZERO));
                            len_acc = (v > longint'(lpmd_pkg::LEN_MAX)) ? lpmd_pkg::LEN_MAX
                                    : v[lpmd_pkg::LEN_BITS-1:0];
                            seen_digit = 1'b1;
                        end else if (!(b == lpmd_pkg::CH_SPACE && !seen_digit)) begin
                            num_closed = 1'b1;
                        end
                    end
                end
                lpmd_pkg::PH_BEFORE: begin
                    if (b == lpmd_pkg::CH_BRACE) begin
                        if (left == '0) begin
                            add_expected(8'h00, 1'b1, 1'b1);
                            clear_parser(!chunk_end);
                        end else begin
                            left = left - 1'b1;
                            if (left == '0) begin
                                add_expected(b, 1'b1, 1'b0);
                                clear_parser(!chunk_end);
                            end else begin
                                add_expected(b, 1'b0, 1'b0);
                                ph = lpmd_pkg::PH_CONTENT;
                            end
                        end
                    end
                end
                lpmd_pkg::PH_CONTENT: begin
                    if (left != '0) begin
                        left = left - 1'b1;
                    end
                    if (left == '0) begin
                        add_expected(b, 1'b1, 1'b0);
                        clear_parser(!chunk_end);
                    end else begin
                        add_expected(b, 1'b0, 1'b0);
                    end
                end
                default: ph = lpmd_pkg::PH_HUNT;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            clear_parser(1'b0);
            frame_bytes.delete();
            fails = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_bytes.size() == 0) begin
                    $display("%0t: result with none pending, expected nothing, got %h/%b/%b",
                             $time, m_tdata, m_tlast, m_tuser);
                    fails++;
                end else begin
                    want = frame_bytes.pop_front();
                    if (m_tdata !== want.data) begin
                        $display("%0t: out_byte expected %h got %h", $time, want.data, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last expected %b got %b", $time, want.last, m_tlast);
                        fails++;
                    end
                    if (m_tuser !== want.empty) begin
                        $display("%0t: empty_res expected %b got %b",
                                 $time, want.empty, m_tuser);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
            end
        end
        pending = frame_bytes.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY_OPEN,
        RX_MOSTLY_SHUT,
        RX_SHUT
    } rx_mode_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    int fails;
    int pending;
    int sent       = 0;
    int burst_left = 0;

    length_prefixed_message_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    deframe_monitor monitor (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .fails    (fails),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic put(input logic [7:0] b, input logic chunk_end);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= chunk_end;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        sent++;
    endtask

    task automatic put_text(input string s, input bit rand_end);
        for (int i = 0; i < s.len(); i++) begin
            put(s[i], rand_end ? 1'($urandom_range(0, 1)) : 1'b0);
        end
    endtask

    function automatic logic [7:0] not_colon();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == lpmd_pkg::CH_COLON) ? 8'h3B : b;
    endfunction

    task automatic put_message();
        int         len;
        int         eff;
        int         kind;
        string      digits;
        logic       fin;
        logic [7:0] b;
        repeat ($urandom_range(0, 3)) put(not_colon(), 1'($urandom_range(0, 1)));
        put(lpmd_pkg::CH_COLON, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 2)) put(lpmd_pkg::CH_SPACE, 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 19)) inside
            [0:11]:  len = $urandom_range(0, 5);
            [12:17]: len = $urandom_range(6, 20);
            default: len = $urandom_range(21, 60);
        endcase
        kind = $urandom_range(0, 9);
        eff  = len;
        if (kind == 0) begin
            eff = 0;
        end else begin
            if (kind == 1) begin
                put($urandom_range(0, 1) ? 8'h2D : 8'h2B, 1'($urandom_range(0, 1)));
                eff = 0;
            end
            digits = $sformatf("%0d", len);
            if (kind == 2) begin
                digits = {"0", digits};
            end
            put_text(digits, 1'b1);
            if (kind == 3 || kind == 4) begin
                b = 8'($urandom);
                if ((b >= lpmd_pkg::CH_ZERO && b <= lpmd_pkg::CH_NINE) ||
                    b == lpmd_pkg::CH_CR) begin
                    b = 8'h2E;
                end
                put(b, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 2)) begin
                    b = 8'($urandom);
                    put((b == lpmd_pkg::CH_CR) ? 8'h0E : b, 1'($urandom_range(0, 1)));
                end
            end
        end
        put(lpmd_pkg::CH_CR, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 2)) begin
            b = 8'($urandom);
            put((b == lpmd_pkg::CH_BRACE) ? 8'h7C : b, 1'($urandom_range(0, 1)));
        end
        fin = 1'($urandom_range(0, 1));
        put(lpmd_pkg::CH_BRACE, (eff <= 1) ? fin : 1'($urandom_range(0, 1)));
        for (int i = 1; i < eff; i++) begin
            put(8'($urandom), (i == eff - 1) ? fin : 1'($urandom_range(0, 1)));
        end
        if (!fin) begin
            repeat ($urandom_range(0, 4)) put(8'($urandom), 1'b0);
            put(8'($urandom), 1'b1);
        end
    endtask

    initial begin
        int base;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // missing number, message ends on a chunk end
        put(lpmd_pkg::CH_COLON, 1'b0);
        put(lpmd_pkg::CH_CR, 1'b0);
        put(lpmd_pkg::CH_BRACE, 1'b1);
        // sign closes the number, then drop the rest of the chunk
        put_text(": -5", 1'b0);
        put(lpmd_pkg::CH_CR, 1'b0);
        put(lpmd_pkg::CH_BRACE, 1'b0);
        put(8'hFF, 1'b0);
        put(lpmd_pkg::CH_COLON, 1'b1);
        put(8'h00, 1'b1);
        // junk after digits, junk before brace, extreme content bytes
        put_text(": 3x9", 1'b0);
        put(lpmd_pkg::CH_CR, 1'b0);
        put(8'h41, 1'b0);
        put(lpmd_pkg::CH_BRACE, 1'b0);
        put(8'h00, 1'b0);
        put(8'hFF, 1'b1);

        base = sent;
        while (sent < base + 650) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) put(not_colon(), 1'($urandom_range(0, 1)));
            end else begin
                put_message();
            end
        end

        // saturating length; the parser never leaves content after this
        put(lpmd_pkg::CH_COLON, 1'b0);
        put_text("99999999", 1'b0);
        put(lpmd_pkg::CH_CR, 1'b0);
        put(lpmd_pkg::CH_BRACE, 1'b0);
        put(8'h5A, 1'b0);
        put(8'hA5, 1'b1);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
        if (fails == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        rx_mode_t mode;
        int       span;
        int       cyc;
        bit       held;
        cyc  = 0;
        held = 1'b0;
        forever begin
            if (!held && cyc >= 400) begin
                // hold off long enough for the block to back up its input
                held = 1'b1;
                mode = RX_SHUT;
                span = 300;
            end else begin
                span = $urandom_range(8, 80);
                case ($urandom_range(0, 9))
                    0, 1, 2: mode = RX_OPEN;
                    3, 4, 8: mode = RX_COIN;
                    5, 6:    mode = RX_MOSTLY_OPEN;
                    7:       mode = RX_MOSTLY_SHUT;
                    default: begin
                        mode = RX_SHUT;
                        span = $urandom_range(100, 200);
                    end
                endcase
            end
            repeat (span) begin
                @(posedge aclk);
                cyc++;
                case (mode)
                    RX_OPEN:        m_tready <= 1'b1;
                    RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY_OPEN: m_tready <= ($urandom_range(0, 7) != 0);
                    RX_MOSTLY_SHUT: m_tready <= ($urandom_range(0, 7) == 0);
                    default:        m_tready <= 1'b0;
                endcase
            end
        end
    end

endmodule

@@ files.f @@
rtl/lpmd_pkg.sv
rtl/lpmd_parser.sv
rtl/length_prefixed_message_deframer.sv
tb/deframe_monitor.sv
tb/tb.sv
